@@ hdl/bavm_pkg.sv @@
// types and constants shared by the byte accumulator vm executor
// used by bavm_ctrl, bavm_dp and byte_accumulator_vm_executor
`default_nettype none

package bavm_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CNT_W  = 32;
	localparam int unsigned DIV_CW = 3;

	// item kinds, carried on s_tuser
	localparam logic [1:0] KIND_EXEC = 2'd0;
	localparam logic [1:0] KIND_MEM  = 2'd1;
	localparam logic [1:0] KIND_REG  = 2'd2;

	// register indexes for register-load items
	localparam logic [1:0] REG_IP  = 2'd0;
	localparam logic [1:0] REG_SP  = 2'd1;
	localparam logic [1:0] REG_EAX = 2'd2;
	localparam logic [1:0] REG_EBX = 2'd3;

	// opcodes
	localparam logic [7:0] OP_HALT         = 8'd0;
	localparam logic [7:0] OP_JUMP         = 8'd1;
	localparam logic [7:0] OP_BNE          = 8'd2;
	localparam logic [7:0] OP_LOAD_SP      = 8'd3;
	localparam logic [7:0] OP_LOAD_EAX_MEM = 8'd4;
	localparam logic [7:0] OP_LOAD_EAX_IB  = 8'd5;
	localparam logic [7:0] OP_STORE_EAX    = 8'd6;
	localparam logic [7:0] OP_LOAD_EBX_MEM = 8'd7;
	localparam logic [7:0] OP_LOAD_EBX_IB  = 8'd8;
	localparam logic [7:0] OP_STORE_EBX    = 8'd9;
	localparam logic [7:0] OP_STORE_1      = 8'd10;
	localparam logic [7:0] OP_INC          = 8'd11;
	localparam logic [7:0] OP_ADD          = 8'd12;
	localparam logic [7:0] OP_MUL          = 8'd13;
	localparam logic [7:0] OP_DIV          = 8'd14;
	localparam logic [7:0] OP_XOR          = 8'd15;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_HALT    = 3'd1;
	localparam logic [2:0] ST_ILLEGAL = 3'd2;
	localparam logic [2:0] ST_SKIP    = 3'd3;
	localparam logic [2:0] ST_DIVZERO = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_PUSH
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic div_step;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic div_go;
		logic div_last;
	} stat_t;

endpackage

`default_nettype wire

@@ hdl/bavm_dp.sv @@
// datapath: register file, data memory, op counter, stop flag, divider, result register
// depends on bavm_pkg; driven by bavm_ctrl through cmd_t and stat_t
`default_nettype none

module bavm_dp #(
	parameter int unsigned MEM_DEPTH = 256
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bavm_pkg::cmd_t  cmd,
	output bavm_pkg::stat_t      stat,
	input  wire logic [23:0]     s_tdata,
	input  wire logic [1:0]      s_tuser,
	input  wire logic            s_tlast,
	output logic [63:0]          m_tdata,
	output logic [3:0]           m_tuser
);

	localparam int unsigned AW = $clog2(MEM_DEPTH);
	localparam logic [11:0] D1 = 12'(MEM_DEPTH);
	localparam logic [11:0] D2 = 12'(MEM_DEPTH * 2);
	localparam logic [11:0] D4 = 12'(MEM_DEPTH * 4);
	localparam logic [11:0] D8 = 12'(MEM_DEPTH * 8);
	localparam int unsigned DIV_CW_W = bavm_pkg::DIV_CW;

	// byte address reduced modulo the memory depth; quotient stays below 16
	function automatic logic [AW-1:0] mem_index(input logic [7:0] a);
		logic [11:0] r;
		r = {4'b0, a};
		if (r >= D8) r = 12'(r - D8);
		if (r >= D4) r = 12'(r - D4);
		if (r >= D2) r = 12'(r - D2);
		if (r >= D1) r = 12'(r - D1);
		return r[AW-1:0];
	endfunction

	// architectural state
	logic [7:0]  ip_q, sp_q, eax_q, ebx_q;
	logic [31:0] cnt_q;
	logic        stopped_q;

	// latched item
	logic [1:0] kind_q;
	logic [7:0] opc_q, addr_q, data_q;
	logic       last_q;

	// memory
	logic [7:0]    mem_q [MEM_DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_byte;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0]    mem_wd;

	// per-item result
	logic [2:0] status_q;
	logic       proceed_q;

	// divider
	logic [7:0]          quo_q, rem_q;
	logic [DIV_CW_W-1:0] div_cnt_q;
	logic [8:0]          div_sh;
	logic                div_ge;

	// next values computed in the execute cycle
	logic [7:0]  ip_n, sp_n, eax_n, ebx_n;
	logic [31:0] cnt_n;
	logic        stop_n, proceed_n;
	logic [2:0]  st_n;
	logic [15:0] prod;
	logic [7:0]  ip_inc1, ip_inc2;
	logic        in_sp_op;

	assign ip_inc1 = 8'(ip_q + 8'd1);
	assign ip_inc2 = 8'(ip_q + 8'd2);
	assign prod    = {8'b0, eax_q} * {8'b0, ebx_q};

	// read issued in the transfer cycle, from the incoming opcode
	assign in_sp_op = (s_tdata[7:0] == bavm_pkg::OP_LOAD_EAX_MEM) ||
	                  (s_tdata[7:0] == bavm_pkg::OP_LOAD_EBX_MEM);
	assign rd_byte  = in_sp_op ? sp_q : ip_inc1;
	assign rd_addr  = mem_index(rd_byte);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (cmd.accept) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= s_tuser;
			opc_q  <= s_tdata[7:0];
			addr_q <= s_tdata[15:8];
			data_q <= s_tdata[23:16];
			last_q <= s_tlast;
		end
	end

	always_comb begin
		ip_n      = ip_q;
		sp_n      = sp_q;
		eax_n     = eax_q;
		ebx_n     = ebx_q;
		cnt_n     = cnt_q;
		stop_n    = stopped_q;
		st_n      = bavm_pkg::ST_OK;
		proceed_n = !stopped_q;
		mem_we    = 1'b0;
		mem_wa    = mem_index(sp_q);
		mem_wd    = eax_q;
		case (kind_q)
			bavm_pkg::KIND_EXEC: begin
				if (stopped_q) begin
					st_n      = bavm_pkg::ST_SKIP;
					proceed_n = 1'b0;
				end else begin
					cnt_n = 32'(cnt_q + 32'd1);
					case (opc_q)
						bavm_pkg::OP_HALT: st_n = bavm_pkg::ST_HALT;
						bavm_pkg::OP_JUMP: ip_n = rdata_q;
						bavm_pkg::OP_BNE: begin
							ip_n = (eax_q != ebx_q) ? rdata_q : ip_inc2;
						end
						bavm_pkg::OP_LOAD_SP: begin
							sp_n = rdata_q;
							ip_n = ip_inc2;
						end
						bavm_pkg::OP_LOAD_EAX_MEM: begin
							eax_n = rdata_q;
							ip_n  = ip_inc1;
						end
						bavm_pkg::OP_LOAD_EAX_IB: begin
							eax_n = rdata_q;
							ip_n  = ip_inc2;
						end
						bavm_pkg::OP_STORE_EAX: begin
							mem_we = cmd.exec;
							ip_n   = ip_inc1;
						end
						bavm_pkg::OP_LOAD_EBX_MEM: begin
							ebx_n = rdata_q;
							ip_n  = ip_inc1;
						end
						bavm_pkg::OP_LOAD_EBX_IB: begin
							ebx_n = rdata_q;
							ip_n  = ip_inc2;
						end
						bavm_pkg::OP_STORE_EBX: begin
							mem_we = cmd.exec;
							mem_wd = ebx_q;
							ip_n   = ip_inc1;
						end
						bavm_pkg::OP_STORE_1: begin
							mem_we = cmd.exec;
							mem_wd = 8'd1;
							ip_n   = ip_inc1;
						end
						bavm_pkg::OP_INC: begin
							eax_n = 8'(eax_q + 8'd1);
							ip_n  = ip_inc1;
						end
						bavm_pkg::OP_ADD: begin
							eax_n = 8'(eax_q + ebx_q);
							ip_n  = ip_inc1;
						end
						bavm_pkg::OP_MUL: begin
							eax_n = prod[7:0];
							ip_n  = ip_inc1;
						end
						bavm_pkg::OP_DIV: begin
							// quotient written later by the divider
							ip_n = ip_inc1;
							if (ebx_q == 8'd0) st_n = bavm_pkg::ST_DIVZERO;
						end
						bavm_pkg::OP_XOR: begin
							eax_n = eax_q ^ ebx_q;
							ip_n  = ip_inc1;
						end
						default: st_n = bavm_pkg::ST_ILLEGAL;
					endcase
					if (st_n == bavm_pkg::ST_HALT || st_n == bavm_pkg::ST_ILLEGAL) begin
						stop_n = 1'b1;
					end
					proceed_n = !stop_n;
				end
				if (last_q) stop_n = 1'b0;
			end
			bavm_pkg::KIND_MEM: begin
				mem_we = cmd.exec;
				mem_wa = mem_index(addr_q);
				mem_wd = data_q;
			end
			bavm_pkg::KIND_REG: begin
				case (addr_q[1:0])
					bavm_pkg::REG_IP:  ip_n  = data_q;
					bavm_pkg::REG_SP:  sp_n  = data_q;
					bavm_pkg::REG_EAX: eax_n = data_q;
					bavm_pkg::REG_EBX: ebx_n = data_q;
					default: ip_n = ip_q;
				endcase
			end
			default: ip_n = ip_q;
		endcase
	end

	assign stat.div_go   = (kind_q == bavm_pkg::KIND_EXEC) && !stopped_q &&
	                       (opc_q == bavm_pkg::OP_DIV) && (ebx_q != 8'd0);
	assign stat.div_last = (div_cnt_q == {DIV_CW_W{1'b1}});

	// restoring divider, one quotient bit per cycle
	assign div_sh = {rem_q, quo_q[7]};
	assign div_ge = (div_sh >= {1'b0, ebx_q});

	always_ff @(posedge clk) begin
		if (cmd.exec && stat.div_go) begin
			quo_q     <= eax_q;
			rem_q     <= 8'd0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q     <= {quo_q[6:0], div_ge};
			rem_q     <= div_ge ? 8'(div_sh - {1'b0, ebx_q}) : div_sh[7:0];
			div_cnt_q <= DIV_CW_W'(div_cnt_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q      <= 8'd0;
			sp_q      <= 8'd0;
			eax_q     <= 8'd0;
			ebx_q     <= 8'd0;
			cnt_q     <= 32'd0;
			stopped_q <= 1'b0;
		end else if (cmd.exec) begin
			ip_q      <= ip_n;
			sp_q      <= sp_n;
			eax_q     <= eax_n;
			ebx_q     <= ebx_n;
			cnt_q     <= cnt_n;
			stopped_q <= stop_n;
		end else if (cmd.div_step && stat.div_last) begin
			eax_q <= {quo_q[6:0], div_ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q  <= st_n;
			proceed_q <= proceed_n;
		end
	end

	// result register, snapshot of the state after the item
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			m_tdata <= {cnt_q, ebx_q, eax_q, sp_q, ip_q};
			m_tuser <= {status_q, proceed_q};
		end
	end

endmodule

`default_nettype wire

@@ hdl/bavm_ctrl.sv @@
// controller: item sequencing, divider stepping and result handoff
// depends on bavm_pkg; commands bavm_dp through cmd_t, reads stat_t
`default_nettype none

module bavm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	input  wire bavm_pkg::stat_t  stat,
	output bavm_pkg::cmd_t        cmd
);

	bavm_pkg::state_t state_q, state_n;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bavm_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			bavm_pkg::S_IDLE: begin
				if (s_tvalid) state_n = bavm_pkg::S_EXEC;
			end
			bavm_pkg::S_EXEC: begin
				state_n = stat.div_go ? bavm_pkg::S_DIV : bavm_pkg::S_PUSH;
			end
			bavm_pkg::S_DIV: begin
				if (stat.div_last) state_n = bavm_pkg::S_PUSH;
			end
			bavm_pkg::S_PUSH: begin
				// next item may be taken in the same cycle as the result
				if (out_free) state_n = s_tvalid ? bavm_pkg::S_EXEC : bavm_pkg::S_IDLE;
			end
			default: state_n = bavm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.exec     = 1'b0;
		cmd.div_step = 1'b0;
		cmd.push     = 1'b0;
		case (state_q)
			bavm_pkg::S_IDLE: s_tready = 1'b1;
			bavm_pkg::S_EXEC: cmd.exec = 1'b1;
			bavm_pkg::S_DIV:  cmd.div_step = 1'b1;
			bavm_pkg::S_PUSH: begin
				s_tready = out_free;
				cmd.push = out_free;
			end
			default: s_tready = 1'b0;
		endcase
		cmd.accept = s_tvalid && s_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || m_tready))
		else $error("result loaded over an untaken result");
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == bavm_pkg::S_EXEC))
		else $error("accepted item not executed next cycle");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bavm_pkg::S_DIV && stat.div_last) |=> (state_q == bavm_pkg::S_PUSH))
		else $error("divider finished without result handoff");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bavm_pkg::S_EXEC || state_q == bavm_pkg::S_DIV) |-> !s_tready)
		else $error("input taken while an item is in work");
`endif

endmodule

`default_nettype wire

@@ hdl/byte_accumulator_vm_executor.sv @@
// byte accumulator vm executor: 8-bit toy machine, one result per input item
// depends on bavm_pkg, bavm_ctrl and bavm_dp
//
// s_* channel: items. s_tuser is the kind (execute, memory load, register load),
// s_tlast closes a batch, s_tdata carries opcode, address and data.
// m_* channel: one result per item, the machine registers and op count after
// the item plus proceed and status.
// An item is transferred when tvalid and tready are both high.
// The memory read is issued in the transfer cycle and the item executes in
// the next one (S_EXEC); a divide with a nonzero divisor then runs the
// bit-serial divider (S_DIV), and the result is loaded into the output
// register in S_PUSH once that register is free. The next item is taken
// while the result register is loaded, and while a result waits the input
// is held off only once the following item is done and needs the register.
// Reset clears the registers, the op count and the stop flag; the data memory
// holds no defined value until written. A stalled receiver holds the result
// stable and stalls the input after at most one more item.
`default_nettype none

module byte_accumulator_vm_executor #(
	parameter int unsigned MEM_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // opcode[7:0], address[15:8], data[23:16]
	input  wire logic [1:0]  s_tuser,  // kind[1:0]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // ip_value[7:0], sp_value[15:8], eax_value[23:16],
	                                   // ebx_value[31:24], executed_count[63:32]
	output logic [3:0]       m_tuser   // proceed[0], status[3:1]
);

	bavm_pkg::cmd_t  cmd;
	bavm_pkg::stat_t stat;

	bavm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bavm_dp #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for byte_accumulator_vm_executor
// depends on bavm_pkg and the block rtl; predicts every result in the bench itself

module testbench;

	localparam int unsigned CYCLE_LIMIT      = 1_000_000;
	localparam logic [7:0]  OP_FIRST_ILLEGAL = bavm_pkg::OP_XOR + 8'd1;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] opcode;
		logic [7:0] address;
		logic [7:0] data;
		logic       last;
	} vm_item_t;

	typedef struct packed {
		logic        proceed;
		logic [2:0]  status;
		logic [7:0]  ip;
		logic [7:0]  sp;
		logic [7:0]  eax;
		logic [7:0]  ebx;
		logic [31:0] op_count;
	} vm_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [3:0]  m_tuser;

	// machine state as the bench sees it
	logic [7:0]  vm_regs [4];
	logic [7:0]  vm_mem [256];
	logic [31:0] vm_op_count;
	logic        vm_halted;

	vm_result_t  pending_results [$];
	vm_result_t  expected_now;
	int unsigned error_count  = 0;
	int unsigned cycle_count  = 0;
	bit          src_gaps_on    = 1'b0;
	bit          sink_stalls_on = 1'b0;

	byte_accumulator_vm_executor i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $realtime, pending_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic vm_result_t vm_execute_step(input vm_item_t it);
		vm_result_t r;
		logic [2:0] st;
		logic [7:0] imm_addr;
		logic [7:0] imm;
		st       = bavm_pkg::ST_OK;
		imm_addr = vm_regs[bavm_pkg::REG_IP] + 8'd1;
		imm      = vm_mem[imm_addr];
		if (it.kind == bavm_pkg::KIND_EXEC) begin
			if (vm_halted) begin
				st = bavm_pkg::ST_SKIP;
			end else begin
				vm_op_count = vm_op_count + 32'd1;
				case (it.opcode)
					bavm_pkg::OP_HALT: st = bavm_pkg::ST_HALT;
					bavm_pkg::OP_JUMP: vm_regs[bavm_pkg::REG_IP] = imm;
					bavm_pkg::OP_BNE: begin
						if (vm_regs[bavm_pkg::REG_EAX] != vm_regs[bavm_pkg::REG_EBX])
							vm_regs[bavm_pkg::REG_IP] = imm;
						else
							vm_regs[bavm_pkg::REG_IP] = vm_regs[bavm_pkg::REG_IP] + 8'd2;
					end
					bavm_pkg::OP_LOAD_SP: begin
						vm_regs[bavm_pkg::REG_SP] = imm;
						vm_regs[bavm_pkg::REG_IP] = vm_regs[bavm_pkg::REG_IP] + 8'd2;
					end
					bavm_pkg::OP_LOAD_EAX_MEM: begin
						vm_regs[bavm_pkg::REG_EAX] = vm_mem[vm_regs[bavm_pkg::REG_SP]];
						vm_regs[bavm_pkg::REG_IP]  = vm_regs[bavm_pkg::REG_IP] + 8'd1;
					end
					bavm_pkg::OP_LOAD_EAX_IB: begin
						vm_regs[bavm_pkg::REG_EAX] = imm;
						vm_regs[bavm_pkg::REG_IP]  = vm_regs[bavm_pkg::REG_IP] + 8'd2;
					end
					bavm_pkg::OP_STORE_EAX: begin
						vm_mem[vm_regs[bavm_pkg::REG_SP]] = vm_regs[bavm_pkg::REG_EAX];
						vm_regs[bavm_pkg::REG_IP] = vm_regs[bavm_pkg::REG_IP] + 8'd1;
					end
					bavm_pkg::OP_LOAD_EBX_MEM: begin
						vm_regs[bavm_pkg::REG_EBX] = vm_mem[vm_regs[bavm_pkg::REG_SP]];
						vm_regs[bavm_pkg::REG_IP]  = vm_regs[bavm_pkg::REG_IP] + 8'd1;
					end
					bavm_pkg::OP_LOAD_EBX_IB: begin
						vm_regs[bavm_pkg::REG_EBX] = imm;
						vm_regs[bavm_pkg::REG_IP]  = vm_regs[bavm_pkg::REG_IP] + 8'd2;
					end
					bavm_pkg::OP_STORE_EBX: begin
						vm_mem[vm_regs[bavm_pkg::REG_SP]] = vm_regs[bavm_pkg::REG_EBX];
						vm_regs[bavm_pkg::REG_IP] = vm_regs[bavm_pkg::REG_IP] + 8'd1;
					end
					bavm_pkg::OP_STORE_1: begin
						vm_mem[vm_regs[bavm_pkg::REG_SP]] = 8'd1;
						vm_regs[bavm_pkg::REG_IP] = vm_regs[bavm_pkg::REG_IP] + 8'd1;
					end
					bavm_pkg::OP_INC: begin
						vm_regs[bavm_pkg::REG_EAX] = vm_regs[bavm_pkg::REG_EAX] + 8'd1;
						vm_regs[bavm_pkg::REG_IP]  = vm_regs[bavm_pkg::REG_IP] + 8'd1;
					end
					bavm_pkg::OP_ADD: begin
						vm_regs[bavm_pkg::REG_EAX] = vm_regs[bavm_pkg::REG_EAX] +
							vm_regs[bavm_pkg::REG_EBX];
						vm_regs[bavm_pkg::REG_IP]  = vm_regs[bavm_pkg::REG_IP] + 8'd1;
					end
					bavm_pkg::OP_MUL: begin
						vm_regs[bavm_pkg::REG_EAX] = vm_regs[bavm_pkg::REG_EAX] *
							vm_regs[bavm_pkg::REG_EBX];
						vm_regs[bavm_pkg::REG_IP]  = vm_regs[bavm_pkg::REG_IP] + 8'd1;
					end
					bavm_pkg::OP_DIV: begin
						vm_regs[bavm_pkg::REG_IP] = vm_regs[bavm_pkg::REG_IP] + 8'd1;
						// zero divisor keeps eax and only flags it
						if (vm_regs[bavm_pkg::REG_EBX] == 8'd0)
							st = bavm_pkg::ST_DIVZERO;
						else
							vm_regs[bavm_pkg::REG_EAX] = vm_regs[bavm_pkg::REG_EAX] /
								vm_regs[bavm_pkg::REG_EBX];
					end
					bavm_pkg::OP_XOR: begin
						vm_regs[bavm_pkg::REG_EAX] = vm_regs[bavm_pkg::REG_EAX] ^
							vm_regs[bavm_pkg::REG_EBX];
						vm_regs[bavm_pkg::REG_IP]  = vm_regs[bavm_pkg::REG_IP] + 8'd1;
					end
					default: st = bavm_pkg::ST_ILLEGAL;
				endcase
				if (st == bavm_pkg::ST_HALT || st == bavm_pkg::ST_ILLEGAL)
					vm_halted = 1'b1;
			end
			r.proceed = !vm_halted;
			// batch end clears the stop only after this item's proceed is taken
			if (it.last)
				vm_halted = 1'b0;
		end else begin
			if (it.kind == bavm_pkg::KIND_MEM)
				vm_mem[it.address] = it.data;
			else if (it.kind == bavm_pkg::KIND_REG)
				vm_regs[it.address[1:0]] = it.data;
			r.proceed = !vm_halted;
		end
		r.status   = st;
		r.ip       = vm_regs[bavm_pkg::REG_IP];
		r.sp       = vm_regs[bavm_pkg::REG_SP];
		r.eax      = vm_regs[bavm_pkg::REG_EAX];
		r.ebx      = vm_regs[bavm_pkg::REG_EBX];
		r.op_count = vm_op_count;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] expv,
			input logic [31:0] actv);
		if (actv !== expv) begin
			error_count++;
			$display("%0t: %s expected %0h actual %0h", $realtime, name, expv, actv);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: result expected none actual tdata %h tuser %h",
					$realtime, m_tdata, m_tuser);
			end else begin
				expected_now = pending_results.pop_front();
				compare_field("proceed", 32'(expected_now.proceed), 32'(m_tuser[0]));
				compare_field("status", 32'(expected_now.status), 32'(m_tuser[3:1]));
				compare_field("ip_value", 32'(expected_now.ip), 32'(m_tdata[7:0]));
				compare_field("sp_value", 32'(expected_now.sp), 32'(m_tdata[15:8]));
				compare_field("eax_value", 32'(expected_now.eax), 32'(m_tdata[23:16]));
				compare_field("ebx_value", 32'(expected_now.ebx), 32'(m_tdata[31:24]));
				compare_field("executed_count", expected_now.op_count, m_tdata[63:32]);
			end
		end
	end

	// result side back-pressure
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	function automatic vm_item_t exec_item(input logic [7:0] op, input logic last);
		vm_item_t it;
		it.kind    = bavm_pkg::KIND_EXEC;
		it.opcode  = op;
		it.address = 8'($urandom);
		it.data    = 8'($urandom);
		it.last    = last;
		return it;
	endfunction

	function automatic vm_item_t load_item(input logic [1:0] kind, input logic [7:0] addr,
			input logic [7:0] data);
		vm_item_t it;
		it.kind    = kind;
		it.opcode  = 8'($urandom);
		it.address = addr;
		it.data    = data;
		it.last    = 1'($urandom);
		return it;
	endfunction

	function automatic logic [7:0] random_opcode();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			return bavm_pkg::OP_HALT;
		if (pick < 8)
			return 8'($urandom_range(OP_FIRST_ILLEGAL, 8'hFF));
		return 8'($urandom_range(bavm_pkg::OP_JUMP, bavm_pkg::OP_XOR));
	endfunction

	// valid stays high after a transfer; the next call or release_input decides
	task automatic send_item(input vm_item_t it);
		if (src_gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.kind;
		s_tlast  <= it.last;
		s_tdata  <= {it.data, it.address, it.opcode};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(vm_execute_step(it));
		@(negedge clk);
	endtask

	task automatic release_input();
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		release_input();
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// every byte gets a value before any opcode can read it
	task automatic test_memory_load();
		src_gaps_on    = 1'b1;
		sink_stalls_on = 1'b1;
		for (int a = 0; a < 256; a++)
			send_item(load_item(bavm_pkg::KIND_MEM, 8'(a), 8'($urandom)));
	endtask

	task automatic test_register_load();
		send_item(load_item(bavm_pkg::KIND_REG, {6'h3F, bavm_pkg::REG_IP}, 8'hFF));
		send_item(load_item(bavm_pkg::KIND_REG, {6'h00, bavm_pkg::REG_SP}, 8'h00));
		send_item(load_item(bavm_pkg::KIND_REG, {6'h2A, bavm_pkg::REG_EAX}, 8'hFF));
		send_item(load_item(bavm_pkg::KIND_REG, {6'h15, bavm_pkg::REG_EBX}, 8'h03));
		send_item(load_item(bavm_pkg::KIND_MEM, 8'hFF, 8'h00));
	endtask

	task automatic test_each_opcode();
		for (logic [7:0] op = bavm_pkg::OP_JUMP; op <= bavm_pkg::OP_XOR; op++)
			send_item(exec_item(op, 1'b0));
	endtask

	task automatic test_divide_by_zero();
		send_item(load_item(bavm_pkg::KIND_REG, {6'h00, bavm_pkg::REG_EBX}, 8'h00));
		send_item(exec_item(bavm_pkg::OP_DIV, 1'b0));
		send_item(load_item(bavm_pkg::KIND_REG, {6'h00, bavm_pkg::REG_EBX}, 8'h07));
		send_item(exec_item(bavm_pkg::OP_DIV, 1'b1));
	endtask

	task automatic test_halt_and_skip();
		send_item(exec_item(bavm_pkg::OP_HALT, 1'b0));
		send_item(exec_item(bavm_pkg::OP_INC, 1'b0));
		send_item(load_item(bavm_pkg::KIND_MEM, 8'h80, 8'hA5));
		send_item(load_item(bavm_pkg::KIND_REG, {6'h3F, bavm_pkg::REG_EBX}, 8'h01));
		send_item(exec_item(bavm_pkg::OP_XOR, 1'b1));
		send_item(exec_item(bavm_pkg::OP_INC, 1'b0));
		send_item(exec_item(bavm_pkg::OP_HALT, 1'b1));
		send_item(exec_item(bavm_pkg::OP_INC, 1'b1));
	endtask

	task automatic test_illegal_opcode();
		send_item(exec_item(OP_FIRST_ILLEGAL, 1'b0));
		send_item(exec_item(8'hFF, 1'b1));
		send_item(exec_item(8'hFF, 1'b1));
		send_item(exec_item(bavm_pkg::OP_INC, 1'b1));
	endtask

	// batches of opcodes closed by tlast, with loads and stray batch ends mixed in
	task automatic test_random_batches(input int unsigned n_items, input bit gaps);
		int unsigned sent;
		int unsigned len;
		logic        close;
		sent = 0;
		while (sent < n_items) begin
			src_gaps_on    = gaps && ($urandom_range(0, 3) != 0);
			sink_stalls_on = gaps && ($urandom_range(0, 3) != 0);
			len = $urandom_range(1, 12);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 6) == 0) begin
					if ($urandom_range(0, 1) == 0)
						send_item(load_item(bavm_pkg::KIND_MEM, 8'($urandom),
							8'($urandom)));
					else
						send_item(load_item(bavm_pkg::KIND_REG, 8'($urandom),
							8'($urandom)));
					sent++;
				end
				close = (k == len - 1) || ($urandom_range(0, 19) == 0);
				send_item(exec_item(random_opcode(), close));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = bavm_pkg::KIND_EXEC;
		s_tlast  = 1'b0;
		vm_regs  = '{default: 8'd0};
		vm_mem   = '{default: 8'd0};
		vm_op_count = '0;
		vm_halted   = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_memory_load();
		test_register_load();
		test_each_opcode();
		test_divide_by_zero();
		test_halt_and_skip();
		test_illegal_opcode();
		test_random_batches(600, 1'b1);
		wait_drained();
		test_random_batches(600, 1'b1);
		src_gaps_on    = 1'b0;
		sink_stalls_on = 1'b0;
		test_random_batches(400, 1'b0);

		wait_drained();
		repeat (16) @(posedge clk);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/bavm_pkg.sv
hdl/bavm_dp.sv
hdl/bavm_ctrl.sv
hdl/byte_accumulator_vm_executor.sv
tb/testbench.sv
